>>> rtl/mmsc_pkg.sv
package mmsc_pkg;

    localparam int MAX_DIM_DEF     = 8;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int ACC_W           = 48;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         elem_index;
        logic signed [15:0] elem_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [ACC_W-1:0] product_value;
        logic [2:0]              out_row;
        logic [2:0]              out_col;
        logic                    last;
        logic                    shape_error;
    } t_out_beat;

    typedef struct packed {
        logic [3:0] a_rows;
        logic [3:0] a_cols;
        logic [3:0] b_rows;
        logic [3:0] b_cols;
    } t_cfg;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       first;
        logic       lastk;
        logic       lastres;
        logic       err;
    } t_tag;

endpackage

>>> rtl/mmsc_seq.sv
module mmsc_seq
    import mmsc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_en,
    input  t_cfg                                 i_cfg,
    output logic                                 o_idle,
    output logic                                 o_s0_valid,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_a_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_b_addr,
    output t_tag                                 o_tag
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int DW = $clog2(MAX_DIM);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_seq_state;

    t_seq_state      r_state, n_state;
    logic [CW-1:0]   r_rows, r_cols, r_inner;
    logic            r_sb, r_sa, r_err;
    logic [DW-1:0]   r_i, r_j, r_k;
    logic [AW-1:0]   r_abase, r_kbc, r_lin;
    logic            r_s0_valid;
    logic [AW-1:0]   r_a_addr, r_b_addr;
    t_tag            r_tag;

    logic [CW-1:0]   ar, ac, br, bc;
    logic            sb, sa;
    logic            k_last, j_last, i_last;
    logic [AW-1:0]   a_addr, b_addr;

    function automatic logic [CW-1:0] f_dim(input logic [3:0] r);
        logic [CW-1:0] d;
        if (r == 4'd0) begin
            d = CW'(1);
        end else if (r > 4'(MAX_DIM)) begin
            d = CW'(MAX_DIM);
        end else begin
            d = CW'(r);
        end
        return d;
    endfunction

    assign ar = f_dim(i_cfg.a_rows);
    assign ac = f_dim(i_cfg.a_cols);
    assign br = f_dim(i_cfg.b_rows);
    assign bc = f_dim(i_cfg.b_cols);
    assign sb = (br == CW'(1)) && (bc == CW'(1));
    assign sa = (ar == CW'(1)) && (ac == CW'(1));

    assign k_last = (CW'(r_k) + CW'(1)) == r_inner;
    assign j_last = (CW'(r_j) + CW'(1)) == r_cols;
    assign i_last = (CW'(r_i) + CW'(1)) == r_rows;

    always_comb begin
        if (r_sb) begin
            a_addr = r_lin;
            b_addr = '0;
        end else if (r_sa) begin
            a_addr = '0;
            b_addr = r_lin;
        end else begin
            a_addr = r_abase + AW'(r_k);
            b_addr = r_kbc + AW'(r_j);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_en && k_last && j_last && i_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_s0_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_en) begin
                r_s0_valid <= (r_state == ST_RUN);
            end
        end
    end

    // shape latch and loop counters
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_sb    <= sb;
            r_sa    <= sa && !sb;
            r_err   <= !sb && !sa && (ac != br);
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_abase <= '0;
            r_kbc   <= '0;
            r_lin   <= '0;
            if (sb) begin
                r_rows  <= ar;
                r_cols  <= ac;
                r_inner <= CW'(1);
            end else if (sa) begin
                r_rows  <= br;
                r_cols  <= bc;
                r_inner <= CW'(1);
            end else if (ac != br) begin
                r_rows  <= CW'(1);
                r_cols  <= CW'(1);
                r_inner <= CW'(1);
            end else begin
                r_rows  <= ar;
                r_cols  <= bc;
                r_inner <= ac;
            end
        end else if (r_state == ST_RUN && i_en) begin
            if (!k_last) begin
                r_k   <= r_k + DW'(1);
                r_kbc <= r_kbc + AW'(r_cols);
            end else begin
                r_k   <= '0;
                r_kbc <= '0;
                r_lin <= r_lin + AW'(1);
                if (!j_last) begin
                    r_j <= r_j + DW'(1);
                end else begin
                    r_j     <= '0;
                    r_i     <= r_i + DW'(1);
                    r_abase <= r_abase + AW'(r_inner);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_addr      <= a_addr;
            r_b_addr      <= b_addr;
            r_tag.row     <= 3'(r_i);
            r_tag.col     <= 3'(r_j);
            r_tag.first   <= (r_k == '0);
            r_tag.lastk   <= k_last;
            r_tag.lastres <= k_last && j_last && i_last;
            r_tag.err     <= r_err;
        end
    end

    assign o_idle     = (r_state == ST_IDLE);
    assign o_s0_valid = r_s0_valid;
    assign o_a_addr   = r_a_addr;
    assign o_b_addr   = r_b_addr;
    assign o_tag      = r_tag;

endmodule

>>> rtl/mmsc_mac.sv
module mmsc_mac
    import mmsc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  t_tag                          i_tag,
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [VALUE_WIDTH-1:0] i_b,
    output logic                          o_valid,
    output t_out_beat                     o_beat
);

    localparam int PW = 2 * VALUE_WIDTH;
    localparam int SW = ((PW > ACC_W) ? PW : ACC_W) + 1;

    logic                    r_valid;
    t_tag                    r_tag;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [SW-1:0]    sum;
    logic signed [ACC_W-1:0] sat;
    logic                    fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag  <= i_tag;
            r_prod <= i_a * i_b;
        end
    end

    always_comb begin
        sum  = (r_tag.first ? SW'(0) : SW'(r_acc)) + SW'(r_prod);
        fits = (sum[SW-1:ACC_W-1] == '0) || (sum[SW-1:ACC_W-1] == '1);
        if (fits) begin
            sat = sum[ACC_W-1:0];
        end else if (sum[SW-1]) begin
            sat = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en && r_valid) begin
            r_acc <= sat;
        end
    end

    assign o_valid              = r_valid && r_tag.lastk;
    assign o_beat.product_value = r_tag.err ? '0 : sat;
    assign o_beat.out_row       = r_tag.row;
    assign o_beat.out_col       = r_tag.col;
    assign o_beat.last          = r_tag.lastres;
    assign o_beat.shape_error   = r_tag.err;

endmodule

>>> rtl/matrix_multiply_with_scalar_case.sv
// Matrix multiply with scalar special cases, Q8.8 in, saturated Q32.16 out.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) sets the
// shapes a_rows, a_cols, b_rows, b_cols; write it only while the block is idle.
// Input channel: a load A or load B beat writes one element of its store;
// a compute beat starts a run, during which o_in_ready stays low.
// A run issues one multiply a cycle on the shared multiply-accumulate unit
// while the output is not stalled, rows * cols * inner multiplies in all,
// where inner is a_cols for a full product and 1 when one operand is 1x1;
// a shape mismatch issues one. The next beat is taken once the sequencer
// is idle again after the last issue. The last multiply of each result passes
// through the address, store read, product and output registers in turn.
// Results leave row-major on o_out_valid/i_out_ready; the last carries last.
// Output register holds a beat while the receiver stalls, and the whole
// issue pipeline freezes with it, so nothing is lost or reordered.
// Reset: shape registers return to 1 and the pipeline empties; the element
// stores are not cleared and must be loaded before they are used.
module matrix_multiply_with_scalar_case
    import mmsc_pkg::*;
#(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_beat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_beat,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    t_cfg                          r_cfg;
    logic signed [VALUE_WIDTH-1:0] r_a_store [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_b_store [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rda, r_rdb;
    logic                          r_s1_valid;
    t_tag                          r_s1_tag;
    logic                          r_out_valid;
    t_out_beat                     r_out_beat;

    logic                          en;
    logic                          idle;
    logic                          in_acc;
    logic                          start;
    logic                          in_range;
    logic [AW-1:0]                 wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_value;
    logic                          s0_valid;
    logic [AW-1:0]                 a_addr, b_addr;
    t_tag                          s0_tag;
    logic                          mac_valid;
    t_out_beat                     mac_beat;

    assign en       = !r_out_valid || i_out_ready;
    assign in_acc   = i_in_valid && o_in_ready;
    assign start    = in_acc && (i_in_beat.opcode == OP_COMPUTE);
    assign in_range = {1'b0, i_in_beat.elem_index} < 7'(DEPTH);
    assign wr_addr  = AW'(i_in_beat.elem_index);
    assign wr_value = VALUE_WIDTH'(i_in_beat.elem_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.a_rows <= 4'd1;
            r_cfg.a_cols <= 4'd1;
            r_cfg.b_rows <= 4'd1;
            r_cfg.b_cols <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_A_ROWS: r_cfg.a_rows <= i_cfg_data;
                CFG_A_COLS: r_cfg.a_cols <= i_cfg_data;
                CFG_B_ROWS: r_cfg.b_rows <= i_cfg_data;
                CFG_B_COLS: r_cfg.b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // element stores, read into registers from the issued addresses
    always_ff @(posedge i_clk) begin
        if (in_acc && in_range && i_in_beat.opcode == OP_LOAD_A) begin
            r_a_store[wr_addr] <= wr_value;
        end
        if (en) begin
            r_rda <= r_a_store[a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_range && i_in_beat.opcode == OP_LOAD_B) begin
            r_b_store[wr_addr] <= wr_value;
        end
        if (en) begin
            r_rdb <= r_b_store[b_addr];
        end
    end

    mmsc_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_en       (en),
        .i_cfg      (r_cfg),
        .o_idle     (idle),
        .o_s0_valid (s0_valid),
        .o_a_addr   (a_addr),
        .o_b_addr   (b_addr),
        .o_tag      (s0_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_tag <= s0_tag;
        end
    end

    mmsc_mac #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_valid),
        .i_tag   (r_s1_tag),
        .i_a     (r_rda),
        .i_b     (r_rdb),
        .o_valid (mac_valid),
        .o_beat  (mac_beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= mac_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && mac_valid) begin
            r_out_beat <= mac_beat;
        end
    end

    assign o_in_ready  = idle && en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
